// ===== design/slkt_pkg.sv =====
// shared types and constants for the sorted leaf key table
`timescale 1ns / 1ps
`default_nettype none

package slkt_pkg;

	localparam int KEY_W    = 32;
	localparam int VAL_W    = 64;
	localparam int SLOT_W   = 5;
	localparam int IDX_W    = 5;
	localparam int STATUS_W = 3;
	localparam int OP_W     = 2;

	typedef enum logic [OP_W-1:0] {
		OP_FIND   = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAR  = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_FOUND     = 3'd0,
		STS_NOT_FOUND = 3'd1,
		STS_INSERTED  = 3'd2,
		STS_FULL      = 3'd3,
		STS_OTHER     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		IDX_ZERO = 2'd0,
		IDX_LO   = 2'd1,
		IDX_MID  = 2'd2,
		IDX_SLOT = 2'd3
	} idx_sel_t;

	typedef enum logic [2:0] {
		S_IDLE      = 3'd0,
		S_PROBE     = 3'd1,
		S_COMPARE   = 3'd2,
		S_INS_CHECK = 3'd3,
		S_SHIFT_RD  = 3'd4,
		S_SHIFT_WR  = 3'd5,
		S_FINISH    = 3'd6
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic     capture;
		logic     probe;
		logic     go_left;
		logic     go_right;
		logic     shift_rd;
		logic     shift_wr;
		logic     put_new;
		logic     clear_fill;
		logic     set_result;
		status_t  res_status;
		idx_sel_t res_idx;
		logic     load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic lo_eq_hi;
		logic key_eq;
		logic key_lt;
		logic full;
		logic bad_slot;
		logic shift_end;
	} stat_t;

endpackage

`default_nettype wire

// ===== design/slkt_ctrl.sv =====
// controller state machine for the sorted leaf key table
`timescale 1ns / 1ps
`default_nettype none

module slkt_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	input  wire logic [slkt_pkg::OP_W-1:0]     opcode,
	output logic                               req_stall,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	input  wire slkt_pkg::stat_t               stat,
	output slkt_pkg::cmd_t                     cmd
);

	slkt_pkg::state_t state_q;
	slkt_pkg::state_t state_nxt;
	logic             rsp_valid_q;

	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slkt_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			slkt_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					case (slkt_pkg::opcode_t'(opcode))
						slkt_pkg::OP_FIND: begin
							state_nxt = slkt_pkg::S_PROBE;
						end
						slkt_pkg::OP_INSERT: begin
							state_nxt = slkt_pkg::S_INS_CHECK;
						end
						slkt_pkg::OP_CLEAR: begin
							cmd.clear_fill = 1'b1;
							cmd.set_result = 1'b1;
							cmd.res_status = slkt_pkg::STS_OTHER;
							cmd.res_idx    = slkt_pkg::IDX_ZERO;
							state_nxt      = slkt_pkg::S_FINISH;
						end
						default: begin
							cmd.set_result = 1'b1;
							cmd.res_status = slkt_pkg::STS_OTHER;
							cmd.res_idx    = slkt_pkg::IDX_ZERO;
							state_nxt      = slkt_pkg::S_FINISH;
						end
					endcase
				end
			end
			slkt_pkg::S_PROBE: begin
				if (stat.lo_eq_hi) begin
					cmd.set_result = 1'b1;
					cmd.res_status = slkt_pkg::STS_NOT_FOUND;
					cmd.res_idx    = slkt_pkg::IDX_LO;
					state_nxt      = slkt_pkg::S_FINISH;
				end else begin
					cmd.probe = 1'b1;
					state_nxt = slkt_pkg::S_COMPARE;
				end
			end
			slkt_pkg::S_COMPARE: begin
				if (stat.key_eq) begin
					cmd.set_result = 1'b1;
					cmd.res_status = slkt_pkg::STS_FOUND;
					cmd.res_idx    = slkt_pkg::IDX_MID;
					state_nxt      = slkt_pkg::S_FINISH;
				end else begin
					cmd.go_left  = stat.key_lt;
					cmd.go_right = !stat.key_lt;
					state_nxt    = slkt_pkg::S_PROBE;
				end
			end
			slkt_pkg::S_INS_CHECK: begin
				if (stat.full) begin
					cmd.set_result = 1'b1;
					cmd.res_status = slkt_pkg::STS_FULL;
					cmd.res_idx    = slkt_pkg::IDX_ZERO;
					state_nxt      = slkt_pkg::S_FINISH;
				end else if (stat.bad_slot) begin
					cmd.set_result = 1'b1;
					cmd.res_status = slkt_pkg::STS_OTHER;
					cmd.res_idx    = slkt_pkg::IDX_ZERO;
					state_nxt      = slkt_pkg::S_FINISH;
				end else begin
					state_nxt = slkt_pkg::S_SHIFT_RD;
				end
			end
			slkt_pkg::S_SHIFT_RD: begin
				if (stat.shift_end) begin
					cmd.put_new    = 1'b1;
					cmd.set_result = 1'b1;
					cmd.res_status = slkt_pkg::STS_INSERTED;
					cmd.res_idx    = slkt_pkg::IDX_SLOT;
					state_nxt      = slkt_pkg::S_FINISH;
				end else begin
					cmd.shift_rd = 1'b1;
					state_nxt    = slkt_pkg::S_SHIFT_WR;
				end
			end
			slkt_pkg::S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_nxt    = slkt_pkg::S_SHIFT_RD;
			end
			slkt_pkg::S_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.load_out = 1'b1;
					state_nxt    = slkt_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = slkt_pkg::S_IDLE;
			end
		endcase
	end

	// an accepted item always moves the controller out of idle on the following cycle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q != slkt_pkg::S_IDLE))
		else $error("accepted item did not start work");

	// a loaded result is offered on the next cycle
	a_load_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp_valid)
		else $error("loaded result not offered");

	// every shift write is followed by the next read step
	a_shift_alternates: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slkt_pkg::S_SHIFT_WR) |=> (state_q == slkt_pkg::S_SHIFT_RD))
		else $error("shift sequence broken");

endmodule

`default_nettype wire

// ===== design/slkt_dp.sv =====
// datapath for the sorted leaf key table: key and value memories, search and shift registers
`timescale 1ns / 1ps
`default_nettype none

module slkt_dp #(
	parameter int CAPACITY = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [slkt_pkg::KEY_W-1:0]       search_key,
	input  wire logic [slkt_pkg::SLOT_W-1:0]      slot,
	input  wire logic [slkt_pkg::VAL_W-1:0]       payload,
	input  wire slkt_pkg::cmd_t                   cmd,
	output slkt_pkg::stat_t                       stat,
	output logic [slkt_pkg::STATUS_W-1:0]         status,
	output logic [slkt_pkg::IDX_W-1:0]            index,
	output logic [slkt_pkg::IDX_W-1:0]            entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > slkt_pkg::SLOT_W) ? CW : slkt_pkg::SLOT_W;

	logic [slkt_pkg::KEY_W-1:0] key_mem [CAPACITY];
	logic [slkt_pkg::VAL_W-1:0] val_mem [CAPACITY];

	logic [slkt_pkg::KEY_W-1:0] key_q;
	logic [slkt_pkg::VAL_W-1:0] val_q;
	logic [MW-1:0]              slot_q;
	logic [CW-1:0]              fill_q;
	logic [CW-1:0]              lo_q;
	logic [CW-1:0]              hi_q;
	logic [CW-1:0]              i_q;
	logic [AW-1:0]              mid_q;
	logic [slkt_pkg::KEY_W-1:0] key_rd_q;
	logic [slkt_pkg::VAL_W-1:0] val_rd_q;
	slkt_pkg::status_t          res_status_q;
	logic [slkt_pkg::IDX_W-1:0] res_idx_q;
	logic [slkt_pkg::STATUS_W-1:0] status_q;
	logic [slkt_pkg::IDX_W-1:0] index_q;
	logic [slkt_pkg::IDX_W-1:0] count_q;

	logic [CW:0]                mid_sum;
	logic [CW-1:0]              mid_full;
	logic [AW-1:0]              mid_c;
	logic [CW-1:0]              i_dec;
	logic [AW-1:0]              rd_addr;
	logic [MW-1:0]              lo_w;
	logic [MW-1:0]              mid_w;
	logic [MW-1:0]              fill_w;
	logic [MW-1:0]              i_w;
	logic [slkt_pkg::IDX_W-1:0] idx_c;

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_full = mid_sum[CW:1];
	assign mid_c    = mid_full[AW-1:0];
	assign i_dec    = i_q - CW'(1);
	assign rd_addr  = cmd.shift_rd ? i_dec[AW-1:0] : mid_c;

	assign lo_w   = MW'(lo_q);
	assign mid_w  = MW'(mid_q);
	assign fill_w = MW'(fill_q);
	assign i_w    = MW'(i_q);

	assign stat.lo_eq_hi  = (lo_q == hi_q);
	assign stat.key_eq    = (key_q == key_rd_q);
	assign stat.key_lt    = (key_q < key_rd_q);
	assign stat.full      = (fill_q == CW'(CAPACITY));
	assign stat.bad_slot  = (slot_q > fill_w);
	assign stat.shift_end = (i_w == slot_q);

	always_comb begin
		case (cmd.res_idx)
			slkt_pkg::IDX_LO:   idx_c = lo_w[slkt_pkg::IDX_W-1:0];
			slkt_pkg::IDX_MID:  idx_c = mid_w[slkt_pkg::IDX_W-1:0];
			slkt_pkg::IDX_SLOT: idx_c = slot_q[slkt_pkg::IDX_W-1:0];
			default:            idx_c = '0;
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.clear_fill) begin
			fill_q <= '0;
		end else if (cmd.put_new) begin
			fill_q <= fill_q + CW'(1);
		end
	end

	// search bounds, shift pointer and the latched item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q  <= search_key;
			val_q  <= payload;
			slot_q <= MW'(slot);
			lo_q   <= '0;
			hi_q   <= fill_q;
			i_q    <= fill_q;
		end
		if (cmd.probe) begin
			mid_q <= mid_c;
		end
		if (cmd.go_left) begin
			hi_q <= CW'(mid_q);
		end
		if (cmd.go_right) begin
			lo_q <= CW'(mid_q) + CW'(1);
		end
		if (cmd.shift_wr) begin
			i_q <= i_dec;
		end
		if (cmd.set_result) begin
			res_status_q <= cmd.res_status;
			res_idx_q    <= idx_c;
		end
		if (cmd.load_out) begin
			status_q <= res_status_q;
			index_q  <= res_idx_q;
			count_q  <= fill_w[slkt_pkg::IDX_W-1:0];
		end
	end

	// key and value memories, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.shift_wr) begin
			key_mem[i_q[AW-1:0]] <= key_rd_q;
			val_mem[i_q[AW-1:0]] <= val_rd_q;
		end else if (cmd.put_new) begin
			key_mem[slot_q[AW-1:0]] <= key_q;
			val_mem[slot_q[AW-1:0]] <= val_q;
		end
		key_rd_q <= key_mem[rd_addr];
		val_rd_q <= val_mem[rd_addr];
	end

	assign status      = status_q;
	assign index       = index_q;
	assign entry_count = count_q;

	// the node never holds more than its capacity
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// a shift only moves entries that sit above the insert slot
	a_shift_above_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_wr |-> (i_w > slot_q))
		else $error("shift below insert slot");

	// a probe only happens on a non-empty search range
	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe |-> (lo_q < hi_q))
		else $error("probe on empty range");

endmodule

`default_nettype wire

// ===== design/sorted_leaf_key_table_core.sv =====
// top level of the sorted leaf key table: one b-tree leaf node with find, insert and clear
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  opcode, search_key, slot, payload
//  rsp      out        rsp_valid / rsp_stall  status, index, entry_count
//
// one item at a time; the memory read is registered, so a search probe takes a probe state
// and a compare state; a find makes at most clog2(CAPACITY+1) probes; an insert moves the
// m entries above its slot up, each by a read state and a write state, and a refused
// insert moves none; the next transfer can be taken in the cycle after the result loads
// reset clears the entry count and the handshake state only; memories hold no reset value
// a new item is taken while a finished result still waits under rsp_stall
`timescale 1ns / 1ps
`default_nettype none

module sorted_leaf_key_table_core #(
	parameter int CAPACITY = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// request channel
	input  wire logic                             req_valid,
	output logic                                  req_stall,
	input  wire logic [slkt_pkg::OP_W-1:0]        opcode,
	input  wire logic [slkt_pkg::KEY_W-1:0]       search_key,
	input  wire logic [slkt_pkg::SLOT_W-1:0]      slot,
	input  wire logic [slkt_pkg::VAL_W-1:0]       payload,
	// response channel
	output logic                                  rsp_valid,
	input  wire logic                             rsp_stall,
	output logic [slkt_pkg::STATUS_W-1:0]         status,
	output logic [slkt_pkg::IDX_W-1:0]            index,
	output logic [slkt_pkg::IDX_W-1:0]            entry_count
);

	// command and status buses between sequencer and datapath
	slkt_pkg::cmd_t  cmd;
	slkt_pkg::stat_t stat;

	// sequencer: takes one transfer, steps the search or shift, hands the result on
	slkt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.opcode    (opcode),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: memories, search bounds, shift pointer, entry count and output register
	slkt_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.search_key  (search_key),
		.slot        (slot),
		.payload     (payload),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.index       (index),
		.entry_count (entry_count)
	);

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for the sorted leaf key table: predicted find, insert and clear results
`timescale 1ns / 1ps

module tb_top;

	localparam int CAPACITY = 16;
	localparam logic [slkt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 40;

	// one expected response transfer
	typedef struct packed {
		slkt_pkg::status_t          status;
		logic [slkt_pkg::IDX_W-1:0] index;
		logic [slkt_pkg::IDX_W-1:0] count;
	} leaf_result_t;

	// outcome of a binary search over the held entries
	typedef struct packed {
		logic       hit;
		logic [5:0] pos;
	} search_hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                          req_valid = 1'b0;
	logic                          req_stall;
	logic [slkt_pkg::OP_W-1:0]     opcode = slkt_pkg::OP_FIND;
	logic [slkt_pkg::KEY_W-1:0]    search_key = '0;
	logic [slkt_pkg::SLOT_W-1:0]   slot = '0;
	logic [slkt_pkg::VAL_W-1:0]    payload = '0;

	logic                          rsp_valid;
	logic                          rsp_stall = 1'b0;
	logic [slkt_pkg::STATUS_W-1:0] status;
	logic [slkt_pkg::IDX_W-1:0]    index;
	logic [slkt_pkg::IDX_W-1:0]    entry_count;

	// idling percentages for the two sides, changed per phase
	int send_idle_pct = 0;
	int rcv_idle_pct = 0;

	int fail_count = 0;
	int results_checked = 0;
	int status_seen [5];

	// predictor copy of the node
	logic [slkt_pkg::KEY_W-1:0] leaf_keys [CAPACITY];
	logic [slkt_pkg::VAL_W-1:0] leaf_vals [CAPACITY];
	int unsigned                leaf_fill = 0;

	leaf_result_t pending_results [$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sorted_leaf_key_table_core #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.opcode      (opcode),
		.search_key  (search_key),
		.slot        (slot),
		.payload     (payload),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.index       (index),
		.entry_count (entry_count)
	);

	// binary search over the entries below the fill count; the first match met wins
	function automatic search_hit_t leaf_search(input logic [slkt_pkg::KEY_W-1:0] key);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		search_hit_t r;
		lo = 0;
		hi = leaf_fill;
		r.hit = 1'b0;
		r.pos = '0;
		while (lo != hi) begin
			mid = (lo + hi) / 2;
			if (key == leaf_keys[mid]) begin
				r.hit = 1'b1;
				r.pos = mid[5:0];
				return r;
			end
			if (key < leaf_keys[mid])
				hi = mid;
			else
				lo = mid + 1;
		end
		r.pos = lo[5:0];
		return r;
	endfunction

	// updates the predictor for one accepted request and gives the response it causes
	task automatic predict_leaf(input logic [slkt_pkg::OP_W-1:0] op,
			input logic [slkt_pkg::KEY_W-1:0] key,
			input logic [slkt_pkg::SLOT_W-1:0] sl, input logic [slkt_pkg::VAL_W-1:0] val,
			output leaf_result_t r);
		search_hit_t s;
		int i;
		r.status = slkt_pkg::STS_OTHER;
		r.index = '0;
		case (op)
			slkt_pkg::OP_FIND: begin
				s = leaf_search(key);
				r.status = s.hit ? slkt_pkg::STS_FOUND : slkt_pkg::STS_NOT_FOUND;
				r.index = s.pos[slkt_pkg::IDX_W-1:0];
			end
			slkt_pkg::OP_INSERT: begin
				// fullness is tested before the slot range
				if (leaf_fill >= CAPACITY) begin
					r.status = slkt_pkg::STS_FULL;
				end else if (sl > leaf_fill) begin
					r.status = slkt_pkg::STS_OTHER;
				end else begin
					for (i = leaf_fill; i > sl; i--) begin
						leaf_keys[i] = leaf_keys[i-1];
						leaf_vals[i] = leaf_vals[i-1];
					end
					leaf_keys[sl] = key;
					leaf_vals[sl] = val;
					leaf_fill++;
					r.status = slkt_pkg::STS_INSERTED;
					r.index = sl;
				end
			end
			slkt_pkg::OP_CLEAR: begin
				leaf_fill = 0;
			end
			default: begin
			end
		endcase
		r.count = leaf_fill[slkt_pkg::IDX_W-1:0];
		status_seen[r.status]++;
	endtask

	// one request transfer, with random idle cycles ahead of it
	task automatic send_item(input logic [slkt_pkg::OP_W-1:0] op,
			input logic [slkt_pkg::KEY_W-1:0] key,
			input logic [slkt_pkg::SLOT_W-1:0] sl, input logic [slkt_pkg::VAL_W-1:0] val);
		leaf_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		opcode     <= op;
		search_key <= key;
		slot       <= sl;
		payload    <= val;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_leaf(op, key, sl, val, r);
		pending_results.push_back(r);
	endtask

	// sender holds off until every outstanding response has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// insert at the slot where the key keeps the node sorted
	task automatic insert_sorted(input logic [slkt_pkg::KEY_W-1:0] key,
			input logic [slkt_pkg::VAL_W-1:0] val);
		search_hit_t s;
		s = leaf_search(key);
		send_item(slkt_pkg::OP_INSERT, key, s.pos[slkt_pkg::SLOT_W-1:0], val);
	endtask

	function automatic logic [slkt_pkg::KEY_W-1:0] pick_key();
		int c;
		c = $urandom_range(99);
		if (c < 8)
			return '0;
		if (c < 16)
			return '1;
		// keys already held give hits and duplicates
		if (c < 50 && leaf_fill > 0)
			return leaf_keys[$urandom_range(leaf_fill - 1)];
		// a narrow range makes near neighbours and collisions likely
		if (c < 70)
			return $urandom_range(63);
		return $urandom;
	endfunction

	function automatic logic [slkt_pkg::VAL_W-1:0] pick_value();
		int c;
		c = $urandom_range(99);
		if (c < 10)
			return '0;
		if (c < 20)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// response side: check each accepted transfer, then draw the next stall
	always @(posedge clk) begin
		leaf_result_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected response: status %0d index %0d entry_count %0d",
					status, index, entry_count);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				results_checked++;
				if (status !== e.status) begin
					$error("status mismatch: expected %0d actual %0d", e.status, status);
					fail_count++;
				end
				if (index !== e.index) begin
					$error("index mismatch: expected %0d actual %0d", e.index, index);
					fail_count++;
				end
				if (entry_count !== e.count) begin
					$error("entry_count mismatch: expected %0d actual %0d", e.count,
						entry_count);
					fail_count++;
				end
			end
		end
		rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	// empty node: searches land on slot 0, inserts past the count are refused
	task automatic test_empty_node();
		send_item(slkt_pkg::OP_FIND, '0, '0, '0);
		send_item(slkt_pkg::OP_FIND, '1, '1, '1);
		send_item(slkt_pkg::OP_INSERT, 32'h5, 5'd1, 64'h5);
		send_item(OP_UNUSED, '1, '1, '1);
		send_item(slkt_pkg::OP_CLEAR, '0, '0, '0);
		wait_drained();
	endtask

	// fill the node to capacity, with a duplicate and an out-of-order key on the way
	task automatic test_fill_to_capacity();
		int i;
		send_item(slkt_pkg::OP_INSERT, '0, 5'd0, '0);
		send_item(slkt_pkg::OP_INSERT, '1, 5'd1, '1);
		for (i = 1; i <= 12; i++)
			insert_sorted(32'h1000 * i, {$urandom, $urandom});
		// duplicate of the smallest key
		send_item(slkt_pkg::OP_INSERT, '0, 5'd0, 64'h1);
		// out-of-order key, the slot is trusted
		send_item(slkt_pkg::OP_INSERT, 32'h8000_0000, 5'd0, 64'h2);
		// full node, with a slot that is also out of range
		send_item(slkt_pkg::OP_INSERT, 32'h1234, 5'd31, '1);
		send_item(slkt_pkg::OP_FIND, '1, '0, '0);
		send_item(slkt_pkg::OP_FIND, '0, '0, '0);
		send_item(slkt_pkg::OP_FIND, 32'h3000, '0, '0);
		send_item(slkt_pkg::OP_CLEAR, '1, '1, '1);
		wait_drained();
	endtask

	// mostly well-formed find and sorted-insert sequences, with noise mixed in
	task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
		int n;
		int pick;
		logic [slkt_pkg::OP_W-1:0] op;
		logic [slkt_pkg::KEY_W-1:0] key;
		logic [slkt_pkg::SLOT_W-1:0] sl;
		logic [slkt_pkg::VAL_W-1:0] val;
		search_hit_t s;
		send_idle_pct = s_pct;
		rcv_idle_pct = r_pct;
		for (n = 0; n < n_items; n++) begin
			// hold-off mid-phase until the pipeline is empty
			if (n == n_items / 2)
				wait_drained();
			pick = $urandom_range(99);
			key = pick_key();
			val = pick_value();
			sl = slkt_pkg::SLOT_W'($urandom_range(31));
			if (leaf_fill == CAPACITY && pick < 12) begin
				op = slkt_pkg::OP_CLEAR;
			end else if (pick < 40) begin
				op = slkt_pkg::OP_FIND;
			end else if (pick < 84) begin
				op = slkt_pkg::OP_INSERT;
				s = leaf_search(key);
				sl = s.pos[slkt_pkg::SLOT_W-1:0];
			end else if (pick < 90) begin
				// random slot: out of range or breaking the key order
				op = slkt_pkg::OP_INSERT;
			end else if (pick < 92) begin
				op = slkt_pkg::OP_CLEAR;
			end else if (pick < 95) begin
				op = OP_UNUSED;
			end else begin
				op = slkt_pkg::OP_W'($urandom_range(3));
			end
			send_item(op, key, sl, val);
		end
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 8;
		rcv_idle_pct = 74;
		test_empty_node();
		test_fill_to_capacity();

		test_random_traffic(350, 8, 74);
		test_random_traffic(350, 74, 8);
		test_random_traffic(350, 0, 0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d responses: %0d found, %0d not found, %0d inserted",
			results_checked, status_seen[slkt_pkg::STS_FOUND],
			status_seen[slkt_pkg::STS_NOT_FOUND], status_seen[slkt_pkg::STS_INSERTED]);
		$display("refused as full %0d, bad slot, clear or unused code %0d",
			status_seen[slkt_pkg::STS_FULL], status_seen[slkt_pkg::STS_OTHER]);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/slkt_pkg.sv
design/slkt_ctrl.sv
design/slkt_dp.sv
design/sorted_leaf_key_table_core.sv
bench/tb_top.sv
